>>> design/kdcf_pkg.sv
// ----------------------------------------------------------------------------
// kdcf_pkg
// Types and constants shared by the keyed deadband change filter: word
// layouts, table entry layout, outcome codes, sequencer states and the
// register map.
// ----------------------------------------------------------------------------
`default_nettype none

package kdcf_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int DB_W   = 16;

    localparam logic [ADDR_W-1:0] REG_DEADBAND   = 3'h0;
    localparam logic [DB_W-1:0]   DEADBAND_RESET = 16'd33;

    typedef enum logic [1:0] {
        OUT_NEW     = 2'd0,
        OUT_CHANGED = 2'd1,
        OUT_WITHIN  = 2'd2,
        OUT_FULL    = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS
    } state_t;

    typedef struct packed {
        logic [63:0]        param_key;
        logic signed [31:0] param_value;
    } req_word_t;

    typedef struct packed {
        logic               report;
        outcome_t           outcome;
        logic [63:0]        key_out;
        logic signed [31:0] value_out;
    } rsp_word_t;

    typedef struct packed {
        logic [63:0]        key;
        logic signed [31:0] last;
    } entry_t;

endpackage

`default_nettype wire

>>> design/keyed_deadband_change_filter.sv
// ----------------------------------------------------------------------------
// keyed_deadband_change_filter
// Report-by-exception table: looks up a 64-bit key in a table of ENTRIES
// slots, replaces the stored Q16.16 value and reports new keys and changes
// beyond the programmable deadband.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/ready    | param_key, param_value
//   rsp     | out       | rsp_valid/ready    | report, outcome, key_out, value_out
//   apb     | in        | psel/penable/pready| deadband at byte address 0
//
// A lookup steps through accept, one table read per slot walked, the last
// compare, then decide. A miss walks every filled slot (none on an empty
// table); a hit stops at its slot.
// Slots fill in order from zero and are never freed, so a fill count marks the
// valid slots; reset clears it at once and needs no clearing pass.
// req_ready is high only while the sequencer is idle. A word may be accepted
// while the previous result still waits in the output register; the decide
// step holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_deadband_change_filter #(
    parameter int ENTRIES = 128
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output      logic                          req_ready,
    input  wire kdcf_pkg::req_word_t           req,
    output      logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    output      kdcf_pkg::rsp_word_t           rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kdcf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [kdcf_pkg::DATA_W-1:0]   pwdata,
    output      logic [kdcf_pkg::DATA_W-1:0]   prdata,
    output      logic                          pready
);

    import kdcf_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    state_t             state_reg, state_next;
    logic [DB_W-1:0]    deadband_reg;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [CNT_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic signed [31:0] last_reg, last_next;
    logic [63:0]        key_reg, key_next;
    logic signed [31:0] val_reg, val_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_word_t          rsp_reg, rsp_next;

    logic               scan_issue;
    logic               match;
    logic               load;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    entry_t             ram_rdata;
    logic signed [32:0] diff;
    logic signed [32:0] db_s;
    logic               changed;
    outcome_t           oc;

    kdcf_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (scan_issue),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign pready    = 1'b1;
    assign prdata    = (paddr == REG_DEADBAND) ? {{(DATA_W-DB_W){1'b0}}, deadband_reg} : '0;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign scan_issue = (state_reg == ST_SCAN) && (scan_idx_reg < fill_reg);
    assign match      = cmp_vld_reg && (ram_rdata.key == key_reg);
    assign load       = ((state_reg == ST_HIT) || (state_reg == ST_MISS))
                        && (!rsp_valid_reg || rsp_ready);

    assign diff    = {val_reg[31], val_reg} - {last_reg[31], last_reg};
    assign db_s    = $signed({{(33-DB_W){1'b0}}, deadband_reg});
    assign changed = (diff > db_s) || (diff < -db_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= DEADBAND_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_DEADBAND))
        begin
            deadband_reg <= pwdata[DB_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cmp_vld_reg   <= cmp_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        last_reg     <= last_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        rsp_reg      <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = scan_issue;
        cmp_idx_next   = scan_idx_reg;
        hit_idx_next   = hit_idx_reg;
        last_next      = last_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_ready ? 1'b0 : rsp_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = hit_idx_reg;
        ram_wdata      = '{key: key_reg, last: val_reg};
        oc             = OUT_FULL;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next      = req.param_key;
                    val_next      = req.param_value;
                    scan_idx_next = '0;
                    state_next    = (fill_reg == '0) ? ST_MISS : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (match)
                begin
                    hit_idx_next = cmp_idx_reg[IDX_W-1:0];
                    last_next    = ram_rdata.last;
                    state_next   = ST_HIT;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == CNT_W'(fill_reg - CNT_W'(1))))
                begin
                    state_next = ST_MISS;
                end
            end
            ST_HIT:
            begin
                oc = changed ? OUT_CHANGED : OUT_WITHIN;
                if (load)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MISS:
            begin
                ram_waddr = fill_reg[IDX_W-1:0];
                oc        = (fill_reg < FULL_CNT) ? OUT_NEW : OUT_FULL;
                if (load)
                begin
                    if (fill_reg < FULL_CNT)
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            rsp_next.report    = (oc == OUT_NEW) || (oc == OUT_CHANGED);
            rsp_next.outcome   = oc;
            rsp_next.key_out   = key_reg;
            rsp_next.value_out = val_reg;
            rsp_valid_next     = 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond table size");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == CNT_W'($past(fill_reg) + CNT_W'(1))))
        else $error("fill count moved by more than one slot");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (oc == OUT_FULL)) |-> (fill_reg == FULL_CNT))
        else $error("table full outcome with free slots");

    a_report_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.report == ((rsp.outcome == OUT_NEW) || (rsp.outcome == OUT_CHANGED))))
        else $error("report flag disagrees with outcome");
`endif

endmodule

`default_nettype wire

>>> design/kdcf_ram.sv
// ----------------------------------------------------------------------------
// kdcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kdcf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_keyed_deadband_change_filter.sv
// ----------------------------------------------------------------------------
// tb_keyed_deadband_change_filter
// Self-checking bench for the keyed deadband change filter. A driver feeds
// request words from a queue and a monitor scores every response word
// against a software copy of the key table, in order. The deadband register
// is written over APB between phases and read back after some writes. A short
// directed part covers field extremes, deadband edges and the new, changed
// and within outcomes. Random phases then fill the table past full, with
// bursty idling on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keyed_deadband_change_filter;

    import kdcf_pkg::*;

    localparam int TABLE_SLOTS = 128;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'h4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_ready;
    req_word_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_word_t rsp;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    // software copy of the table and the deadband
    bit slot_valid [TABLE_SLOTS];
    logic [63:0] slot_key [TABLE_SLOTS];
    logic signed [31:0] slot_last [TABLE_SLOTS];
    logic [15:0] band = DEADBAND_RESET;

    req_word_t param_q [$];
    rsp_word_t due_rsp_q [$];
    logic [63:0] known_keys [$];
    logic [31:0] known_last [$];

    logic req_fire = 1'b0;
    bit calm = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int rsp_count = 0;
    int mismatches = 0;

    keyed_deadband_change_filter #(.ENTRIES(TABLE_SLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic rsp_word_t classify_word(req_word_t w);
        rsp_word_t r;
        int hit;
        int spare;
        longint v;
        longint last;
        longint db;
        hit = -1;
        spare = -1;
        v = longint'(w.param_value);
        db = longint'(band);
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (hit < 0 && slot_valid[i] && slot_key[i] == w.param_key)
                hit = i;
            if (spare < 0 && !slot_valid[i])
                spare = i;
        end
        r.key_out = w.param_key;
        r.value_out = w.param_value;
        if (hit >= 0)
        begin
            last = longint'(slot_last[hit]);
            if (v > last + db || v < last - db)
                r.outcome = OUT_CHANGED;
            else
                r.outcome = OUT_WITHIN;
            slot_last[hit] = w.param_value;
        end
        else if (spare >= 0)
        begin
            slot_valid[spare] = 1'b1;
            slot_key[spare] = w.param_key;
            slot_last[spare] = w.param_value;
            r.outcome = OUT_NEW;
        end
        else
            r.outcome = OUT_FULL;
        r.report = (r.outcome == OUT_NEW || r.outcome == OUT_CHANGED);
        return r;
    endfunction

    task automatic queue_word(logic [63:0] k, logic [31:0] v);
        req_word_t w;
        int idx;
        idx = -1;
        for (int i = 0; i < known_keys.size(); i++)
        begin
            if (idx < 0 && known_keys[i] == k)
                idx = i;
        end
        if (idx < 0)
        begin
            known_keys = {known_keys, k};
            known_last = {known_last, v};
        end
        else
            known_last[idx] = v;
        w.param_key = k;
        w.param_value = v;
        param_q = {param_q, w};
    endtask

    task automatic load_random_phase(int count, int fresh_pct);
        int idx;
        int n;
        logic [63:0] k;
        logic [31:0] v;
        logic [31:0] db;
        logic [31:0] last;
        db = 32'(band);
        repeat (count)
        begin
            n = known_keys.size();
            if ($urandom_range(0, 99) < fresh_pct)
            begin
                if ($urandom_range(0, 7) == 0)
                    k = known_keys[$urandom_range(0, n - 1)] ^ (64'd1 << $urandom_range(0, 63));
                else
                    k = {$urandom, $urandom};
                case ($urandom_range(0, 7))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    default: v = $urandom;
                endcase
            end
            else
            begin
                if (n > 150 && $urandom_range(0, 4) != 0)
                    n = 150;
                idx = $urandom_range(0, n - 1);
                k = known_keys[idx];
                last = known_last[idx];
                case ($urandom_range(0, 8))
                    0: v = last - db - 1;
                    1: v = last - db;
                    2: v = last;
                    3: v = last + db;
                    4: v = last + db + 1;
                    5: v = last + $urandom_range(0, 2 * db + 2) - db - 1;
                    6: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: v = $urandom;
                endcase
            end
            queue_word(k, v);
        end
    endtask

    task automatic drain();
        while (param_q.size() != 0 || req_valid || due_rsp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_DEADBAND)
            band = data[DB_W-1:0];
    endtask

    task automatic apb_check_read();
        logic [DATA_W-1:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= REG_DEADBAND;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        if (got !== {{(DATA_W-DB_W){1'b0}}, band})
            flag_mismatch("prdata", 64'(got), 64'(band));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_fire))
        begin
            if (send_gap != 0)
            begin
                send_gap = send_gap - 1;
                req_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 11);
                req_valid <= 1'b0;
            end
            else if (param_q.size() != 0)
            begin
                req <= param_q.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && rsp_count >= 350)
            begin
                hold_done = 1'b1;
                hold_left = 600;
                rsp_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin : monitor
        rsp_word_t want;
        req_fire <= req_valid && req_ready;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_count++;
                if (due_rsp_q.size() == 0)
                    flag_mismatch("unexpected word", rsp.key_out, '0);
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (rsp.report !== want.report)
                        flag_mismatch("report", 64'(rsp.report), 64'(want.report));
                    if (rsp.outcome !== want.outcome)
                        flag_mismatch("outcome", 64'(rsp.outcome), 64'(want.outcome));
                    if (rsp.key_out !== want.key_out)
                        flag_mismatch("key_out", rsp.key_out, want.key_out);
                    if (rsp.value_out !== want.value_out)
                        flag_mismatch("value_out", 64'(rsp.value_out), 64'(want.value_out));
                end
            end
            if (req_valid && req_ready)
                due_rsp_q = {due_rsp_q, classify_word(req)};
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        apb_check_read();

        queue_word(64'h0, 32'd0);
        queue_word(64'h0, 32'd33);
        queue_word(64'h0, 32'd67);
        queue_word(64'h0, 32'd34);
        queue_word(64'h0, 32'd0);
        queue_word(64'h0, -32'sd33);
        queue_word(64'h0, -32'sd67);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
        queue_word(64'h8000_0000_0000_0001, 32'hFFFF_FFFF);
        queue_word(64'h0000_0000_0000_0001, 32'h0000_0001);
        drain();

        apb_write(REG_DEADBAND, 32'hA5C3_0000);
        apb_check_read();
        queue_word(64'h0, -32'sd67);
        queue_word(64'h0, -32'sd66);
        queue_word(64'h0, -32'sd67);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0001);
        drain();

        apb_write(REG_DEADBAND, 32'hFFFF_FFFF);
        apb_check_read();
        queue_word(64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_0000);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFE_FFFF);
        queue_word(64'h0, 32'd0);
        queue_word(64'h0, 32'd65469);
        drain();

        apb_write(ADDR_UNUSED, $urandom);
        apb_check_read();

        apb_write(REG_DEADBAND, $urandom);
        load_random_phase(300, 50);
        drain();

        apb_write(REG_DEADBAND, {16'($urandom_range(0, 65535)), 16'h0000});
        load_random_phase(300, 15);
        drain();

        apb_write(REG_DEADBAND, $urandom_range(1, 300));
        apb_check_read();
        load_random_phase(300, 10);
        drain();

        calm = 1'b1;
        apb_write(REG_DEADBAND, 32'h0000_FFFF);
        load_random_phase(300, 10);
        drain();

        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("keyed_deadband_change_filter verification clean");
        else
            $display("keyed_deadband_change_filter verification failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("keyed_deadband_change_filter verification failed");
        $finish;
    end

endmodule

`default_nettype wire
